@@ rtl/core/fqt_pkg.sv @@
`default_nettype none

package fqt_pkg;

  localparam int KEY_W = 10;
  localparam int CNT_W = 10;
  localparam int BKT_W = 11;
  localparam int REQ_W = 2;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1023);

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_DEL   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY_RD,
    ST_OLD_RD,
    ST_OLD_WR,
    ST_NEW_RD,
    ST_NEW_WR,
    ST_Q_RD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [BKT_W-1:0] a;
    logic             dec;
  } alu_req_t;

endpackage

`default_nettype wire

@@ rtl/core/frequency_tracker_table.sv @@
`default_nettype none

// Channel  Dir  tdata (low bit up)                    tuser
// s_*      in   key[9:0], query_freq[19:10], pad     req_type[1:0]
// m_*      out  found[0], key_count[10:1],           -
//               saturated[11], pad
//
// One item at a time through a sequencer sharing one +/-1 unit.
// Add/delete: a key read, then up to two bucket read-modify-writes. Query:
// one bucket read. Saturated add and absent delete end after the key read.
// After reset, a clearing pass zeroes all 1024 entries of both tables; s_tready is low.
// The result register lets the next item be taken while m_tready is low.

module frequency_tracker_table (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [fqt_pkg::IN_TDATA_W-1:0]      s_tdata,  // key, query_freq
  input  wire  [fqt_pkg::REQ_W-1:0]           s_tuser,  // req_type
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [fqt_pkg::OUT_TDATA_W-1:0]     m_tdata   // found, key_count, saturated
);

  fqt_pkg::state_t state, state_next;

  logic [fqt_pkg::KEY_W-1:0] clr_idx;
  logic [fqt_pkg::REQ_W-1:0] req;
  logic [fqt_pkg::KEY_W-1:0] key;
  logic [fqt_pkg::CNT_W-1:0] qf;
  logic [fqt_pkg::CNT_W-1:0] cnt_old;
  logic [fqt_pkg::CNT_W-1:0] cnt_new;
  logic                      need_new;
  logic                      res_found;
  logic [fqt_pkg::CNT_W-1:0] res_kc;
  logic                      res_sat;

  logic                      cpk_we;
  logic [fqt_pkg::KEY_W-1:0] cpk_waddr;
  logic [fqt_pkg::CNT_W-1:0] cpk_wdata;
  logic [fqt_pkg::CNT_W-1:0] cpk_rdata;
  logic                      kpc_we;
  logic [fqt_pkg::CNT_W-1:0] kpc_waddr;
  logic [fqt_pkg::BKT_W-1:0] kpc_wdata;
  logic [fqt_pkg::CNT_W-1:0] kpc_raddr;
  logic [fqt_pkg::BKT_W-1:0] kpc_rdata;

  fqt_pkg::alu_req_t         alu_req;
  logic [fqt_pkg::BKT_W-1:0] alu_y;

  logic                      accept;
  logic                      out_free;
  logic                      clr_last;
  logic [fqt_pkg::KEY_W-1:0] in_key;
  logic [fqt_pkg::CNT_W-1:0] in_qf;
  logic [fqt_pkg::CNT_W-1:0] key_cnt;
  logic                      is_add;

  assign in_key   = s_tdata[fqt_pkg::KEY_W-1:0];
  assign in_qf    = s_tdata[fqt_pkg::KEY_W +: fqt_pkg::CNT_W];
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign clr_last = (clr_idx == {fqt_pkg::KEY_W{1'b1}});
  assign key_cnt  = cpk_rdata;
  assign is_add   = (req == fqt_pkg::REQ_ADD);

  fqt_ram #(.ADDR_W(fqt_pkg::KEY_W), .DATA_W(fqt_pkg::CNT_W)) u_cpk (
    .clk   (clk),
    .we    (cpk_we),
    .waddr (cpk_waddr),
    .wdata (cpk_wdata),
    .raddr (in_key),
    .rdata (cpk_rdata)
  );

  fqt_ram #(.ADDR_W(fqt_pkg::CNT_W), .DATA_W(fqt_pkg::BKT_W)) u_kpc (
    .clk   (clk),
    .we    (kpc_we),
    .waddr (kpc_waddr),
    .wdata (kpc_wdata),
    .raddr (kpc_raddr),
    .rdata (kpc_rdata)
  );

  fqt_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fqt_pkg::ST_CLEAR: begin
        if (clr_last) state_next = fqt_pkg::ST_IDLE;
      end
      fqt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (fqt_pkg::req_t'(s_tuser))
            fqt_pkg::REQ_ADD,
            fqt_pkg::REQ_DEL:   state_next = fqt_pkg::ST_KEY_RD;
            fqt_pkg::REQ_QUERY: state_next = fqt_pkg::ST_Q_RD;
            default:            state_next = fqt_pkg::ST_DONE;
          endcase
        end
      end
      fqt_pkg::ST_KEY_RD: begin
        if (is_add) begin
          if (key_cnt == fqt_pkg::COUNT_MAX) state_next = fqt_pkg::ST_DONE;
          else if (key_cnt != '0)            state_next = fqt_pkg::ST_OLD_RD;
          else                               state_next = fqt_pkg::ST_NEW_RD;
        end else begin
          if (key_cnt == '0) state_next = fqt_pkg::ST_DONE;
          else               state_next = fqt_pkg::ST_OLD_RD;
        end
      end
      fqt_pkg::ST_OLD_RD: state_next = fqt_pkg::ST_OLD_WR;
      fqt_pkg::ST_OLD_WR: begin
        if (need_new) state_next = fqt_pkg::ST_NEW_RD;
        else          state_next = fqt_pkg::ST_DONE;
      end
      fqt_pkg::ST_NEW_RD: state_next = fqt_pkg::ST_NEW_WR;
      fqt_pkg::ST_NEW_WR: state_next = fqt_pkg::ST_DONE;
      fqt_pkg::ST_Q_RD:   state_next = fqt_pkg::ST_DONE;
      fqt_pkg::ST_DONE: begin
        if (out_free) state_next = fqt_pkg::ST_IDLE;
      end
      default: state_next = fqt_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready    = 1'b0;
    cpk_we      = 1'b0;
    cpk_waddr   = key;
    cpk_wdata   = alu_y[fqt_pkg::CNT_W-1:0];
    kpc_we      = 1'b0;
    kpc_waddr   = cnt_old;
    kpc_wdata   = alu_y;
    kpc_raddr   = cnt_old;
    alu_req.a   = kpc_rdata;
    alu_req.dec = 1'b1;
    unique case (state)
      fqt_pkg::ST_CLEAR: begin
        cpk_we    = 1'b1;
        cpk_waddr = clr_idx;
        cpk_wdata = '0;
        kpc_we    = 1'b1;
        kpc_waddr = clr_idx;
        kpc_wdata = '0;
      end
      fqt_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        kpc_raddr = in_qf;
      end
      fqt_pkg::ST_KEY_RD: begin
        alu_req.a   = {1'b0, key_cnt};
        alu_req.dec = !is_add;
        cpk_we      = is_add ? (key_cnt != fqt_pkg::COUNT_MAX) : (key_cnt != '0);
      end
      fqt_pkg::ST_OLD_RD: kpc_raddr = cnt_old;
      fqt_pkg::ST_OLD_WR: kpc_we = 1'b1;
      fqt_pkg::ST_NEW_RD: kpc_raddr = cnt_new;
      fqt_pkg::ST_NEW_WR: begin
        alu_req.dec = 1'b0;
        kpc_we      = 1'b1;
        kpc_waddr   = cnt_new;
      end
      fqt_pkg::ST_Q_RD,
      fqt_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fqt_pkg::ST_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fqt_pkg::ST_CLEAR) clr_idx <= clr_idx + fqt_pkg::KEY_W'(1);
      if (state == fqt_pkg::ST_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req       <= s_tuser;
      key       <= in_key;
      qf        <= in_qf;
      res_found <= 1'b0;
      res_kc    <= '0;
      res_sat   <= 1'b0;
    end
    unique case (state)
      fqt_pkg::ST_KEY_RD: begin
        cnt_old  <= key_cnt;
        cnt_new  <= alu_y[fqt_pkg::CNT_W-1:0];
        need_new <= (alu_y != '0);
        if (is_add && key_cnt == fqt_pkg::COUNT_MAX) begin
          res_kc  <= fqt_pkg::COUNT_MAX;
          res_sat <= 1'b1;
        end else if (is_add || key_cnt != '0) begin
          res_kc <= alu_y[fqt_pkg::CNT_W-1:0];
        end
      end
      fqt_pkg::ST_Q_RD: res_found <= (qf != '0) && (kpc_rdata != '0);
      fqt_pkg::ST_DONE: begin
        if (out_free) begin
          m_tdata <= {{(fqt_pkg::OUT_TDATA_W - fqt_pkg::CNT_W - 2){1'b0}},
                      res_sat, res_kc, res_found};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/fqt_alu.sv @@
`default_nettype none

module fqt_alu (
  input  wire fqt_pkg::alu_req_t                req,
  output logic [fqt_pkg::BKT_W-1:0] y
);

  always_comb begin
    if (req.dec) begin
      y = req.a - fqt_pkg::BKT_W'(1);
    end else begin
      y = req.a + fqt_pkg::BKT_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fqt_ram.sv @@
`default_nettype none

module fqt_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 10
) (
  input  wire               clk,
  input  wire               we,
  input  wire  [ADDR_W-1:0] waddr,
  input  wire  [DATA_W-1:0] wdata,
  input  wire  [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
